// ===== sv/jetp_pkg.sv =====
package jetp_pkg;

	localparam int FRAC_BITS = 20;
	localparam int Q_W = 24;
	localparam int PROD_W = 48;
	localparam int IDX_W = 6;
	localparam int IDX_N = 1 << IDX_W;
	localparam int COUNT_W = 7;
	localparam int CNT_EXT_W = 11;
	localparam int WR_INDEX_W = 2;

	localparam int GRID_SIZE_DEF = 64;
	localparam int MAX_ITER_DEF = 64;

	localparam longint Q_MAX = 64'sd8388607;
	localparam longint Q_MIN = -64'sd8388608;
	localparam longint ONE_Q = 64'sd1 << FRAC_BITS;

	localparam logic [WR_INDEX_W-1:0] REG_C_REAL = 2'd0;
	localparam logic [WR_INDEX_W-1:0] REG_C_IMAG = 2'd1;

	localparam logic signed [Q_W:0] ESC_LIMIT = 25'sd4194304;
	localparam logic [CNT_EXT_W-1:0] COUNT_CAP = 11'd127;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic update;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic finish;
	} status_t;

	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'(Q_MAX);
		lo = PROD_W'(Q_MIN);
		if (v > hi) begin
			sat_q = Q_W'(Q_MAX);
		end else if (v < lo) begin
			sat_q = Q_W'(Q_MIN);
		end else begin
			sat_q = v[Q_W-1:0];
		end
	endfunction

endpackage

// ===== sv/jetp_ctrl.sv =====
module jetp_ctrl
	import jetp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pixel_valid,
	output logic    pixel_ready,
	output logic    count_valid,
	input  logic    count_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (count_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		pixel_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pixel_ready = 1'b1;
				if (pixel_valid) begin
					cmd.load = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (status.finish) begin
					if (!out_valid_q || count_ready) begin
						cmd.out_load = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.update = 1'b1;
					state_d = ST_MUL;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign count_valid = out_valid_q;

endmodule

// ===== sv/jetp_datapath.sv =====
module jetp_datapath
	import jetp_pkg::*;
#(
	parameter int GRID_SIZE = GRID_SIZE_DEF,
	parameter int MAX_ITER = MAX_ITER_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [WR_INDEX_W-1:0] wr_index,
	input  logic [Q_W-1:0]        wr_data,
	input  logic [IDX_W-1:0]      pixel_col,
	input  logic [IDX_W-1:0]      pixel_row,
	input  cmd_t                  cmd,
	output status_t               status,
	output logic [COUNT_W-1:0]    iter_count
);

	localparam int CNT_W = $clog2(MAX_ITER + 1);

	logic signed [Q_W-1:0]    start_tab [IDX_N];
	logic signed [Q_W-1:0]    c_real_q;
	logic signed [Q_W-1:0]    c_imag_q;
	logic signed [Q_W-1:0]    x_q;
	logic signed [Q_W-1:0]    y_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [PROD_W-1:0] xx_s1;
	logic signed [PROD_W-1:0] yy_s1;
	logic signed [PROD_W-1:0] xy_s1;
	logic [COUNT_W-1:0]       iter_count_q;
	logic signed [Q_W-1:0]    x2;
	logic signed [Q_W-1:0]    y2;
	logic signed [Q_W:0]      sq_sum;
	logic signed [Q_W-1:0]    nx;
	logic signed [Q_W-1:0]    ny;
	logic                     escape;
	logic                     at_max;
	logic [CNT_EXT_W-1:0]     cnt_ext;

	for (genvar i = 0; i < IDX_N; i++) begin : g_start
		localparam longint NUM = longint'(i) * 3 * ONE_Q;
		localparam longint RAW = NUM / GRID_SIZE - (3 * ONE_Q) / 2;
		localparam longint SAT = (RAW > Q_MAX) ? Q_MAX : ((RAW < Q_MIN) ? Q_MIN : RAW);
		assign start_tab[i] = Q_W'(SAT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_real_q <= '0;
			c_imag_q <= '0;
		end else if (wr_en) begin
			if (wr_index == REG_C_REAL) begin
				c_real_q <= wr_data;
			end
			if (wr_index == REG_C_IMAG) begin
				c_imag_q <= wr_data;
			end
		end
	end

	assign x2 = sat_q(xx_s1 >>> FRAC_BITS);
	assign y2 = sat_q(yy_s1 >>> FRAC_BITS);
	assign sq_sum = (Q_W+1)'(x2) + (Q_W+1)'(y2);
	assign escape = sq_sum > ESC_LIMIT;
	assign at_max = cnt_q == CNT_W'(MAX_ITER);
	assign nx = sat_q(PROD_W'(x2) - PROD_W'(y2) + PROD_W'(c_real_q));
	assign ny = sat_q((xy_s1 >>> (FRAC_BITS - 1)) + PROD_W'(c_imag_q));
	assign status.finish = at_max || escape;
	assign cnt_ext = CNT_EXT_W'(cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= start_tab[pixel_col];
			y_q <= start_tab[pixel_row];
			cnt_q <= '0;
		end else if (cmd.update) begin
			x_q <= nx;
			y_q <= ny;
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.mul) begin
			xx_s1 <= x_q * x_q;
			yy_s1 <= y_q * y_q;
			xy_s1 <= x_q * y_q;
		end
		if (cmd.out_load) begin
			iter_count_q <= (cnt_ext > COUNT_CAP) ? COUNT_CAP[COUNT_W-1:0]
				: cnt_ext[COUNT_W-1:0];
		end
	end

	assign iter_count = iter_count_q;

endmodule

// ===== sv/julia_escape_time_pixel.sv =====
// Channel   Handshake                  Payload
// pixel     pixel_valid/pixel_ready    pixel_col[5:0], pixel_row[5:0]
// count     count_valid/count_ready    iter_count[6:0]
// config    wr_en (no wait)            wr_index[1:0], wr_data[23:0]
//
// One pixel is worked on at a time: a request is loaded, then runs escape tests, each
// a multiply step, then a test and update step; a count of n takes n + 1 tests.
// Each multiply step uses the three 24x24 multipliers.
// Reset clears the controller, the output flag and both constant registers.
// A finished count waits in the output register; the next request is taken meanwhile,
// and a later count holds in the datapath until the output register frees.
module julia_escape_time_pixel
	import jetp_pkg::*;
#(
	parameter int GRID_SIZE = GRID_SIZE_DEF,
	parameter int MAX_ITER = MAX_ITER_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [WR_INDEX_W-1:0] wr_index,
	input  logic [Q_W-1:0]        wr_data,
	input  logic                  pixel_valid,
	output logic                  pixel_ready,
	input  logic [IDX_W-1:0]      pixel_col,
	input  logic [IDX_W-1:0]      pixel_row,
	output logic                  count_valid,
	input  logic                  count_ready,
	output logic [COUNT_W-1:0]    iter_count
);

	cmd_t    cmd;
	status_t status;

	jetp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.count_valid (count_valid),
		.count_ready (count_ready),
		.status      (status),
		.cmd         (cmd)
	);

	jetp_datapath #(
		.GRID_SIZE (GRID_SIZE),
		.MAX_ITER  (MAX_ITER)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.pixel_col  (pixel_col),
		.pixel_row  (pixel_row),
		.cmd        (cmd),
		.status     (status),
		.iter_count (iter_count)
	);

endmodule
